// File: rtl/clml_pkg.sv
`timescale 1ns / 1ps

package clml_pkg;

    // operation codes of an input item
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_STEP = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_GAIN_A       = 2'd0,
        CFG_COUPLING_EPS = 2'd1,
        CFG_SITE_COUNT   = 2'd2,
        CFG_NONE         = 2'd3
    } t_cfg_idx;

    // control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_STEP
    } t_state;

    typedef struct packed {
        t_op         operation;
        logic [7:0]  site_index;
        logic [31:0] site_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_index;
        logic [31:0] read_value;
    } t_out_item;

    localparam int          MIN_SITES      = 3;
    localparam logic [31:0] GAIN_A_RESET   = 32'd2093796557;
    localparam logic [31:0] EPS_RESET      = 32'd42949673;
    localparam logic [8:0]  SITES_RESET    = 9'd256;
    // 4.0 in Q3.29 and 0.5 in Q0.32 share one code
    localparam logic [31:0] PARAM_SAT      = 32'h8000_0000;
    // 1.0 in Q1.31, one in Q.32
    localparam logic [32:0] ONE_Q31        = 33'h0_8000_0000;
    localparam logic [32:0] ONE_Q32        = 33'h1_0000_0000;

endpackage

// File: rtl/clml_ram.sv
`timescale 1ns / 1ps

module clml_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/coupled_logistic_map_lattice.sv
`timescale 1ns / 1ps

// Ring lattice of coupled logistic maps, double-buffered in one RAM.
// Input channel (i_in_valid / o_in_stall) carries load, step and read items;
// output channel (o_out_valid / i_out_stall) returns one item per read.
// Configuration writes (gain, coupling, site count) come over the cfg
// channel, which is always ready; write only while the block is idle.
// Load: writes the site, no result. Read: the site RAM output and then the
// result register are registered after the transfer; while the output
// register is still held by a stalled receiver, the read waits and the
// input channel stalls. Step: all n sites stream through the single read
// port of the site RAM and a multiply pipeline into the other bank; the
// bank then flips. Reset clears the control state and selects bank zero;
// site values are undefined until loaded. A read of a site index not below
// the ring size returns zero; loads to such an index are dropped.
module coupled_logistic_map_lattice #(
    parameter int MAX_SITES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  clml_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output clml_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  clml_pkg::t_cfg_idx   i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    import clml_pkg::*;

    localparam int AW  = $clog2(MAX_SITES);
    localparam int SW  = $clog2(MAX_SITES + 1);
    localparam int CW  = (SW > 9) ? SW : 9;
    localparam int KW  = CW + 1;
    localparam int RAW = AW + 1;

    // configuration registers
    logic [31:0]  r_gain_a;
    logic [31:0]  r_eps;
    logic [8:0]   r_site_count;

    // control
    t_state       r_state, n_state;
    logic         r_bank;
    logic [RAW-1:0] r_raddr;
    logic [7:0]   r_rd_idx;
    logic         r_rd_oor;
    logic         r_out_valid;
    t_out_item    r_out_data;
    logic [KW-1:0] r_k;
    logic [CW-1:0] r_wsite;
    logic [1:0]   r_fcnt;
    logic         r_v1, r_v2, r_v3, r_v4, r_v5;

    // datapath
    logic signed [33:0] r_fl, r_fc, r_fr;
    logic signed [33:0] r_t1, r_t2;
    logic signed [34:0] r_s;
    logic signed [67:0] r_p;

    // derived values
    logic [CW-1:0]  ring_n;
    logic [CW-1:0]  cnt_ext;
    logic [31:0]    a_sat;
    logic [31:0]    e_sat;
    logic [32:0]    c_coef;
    logic           in_xfer;
    logic           out_xfer;
    logic           idx_ok;
    logic           issue;
    logic           out_load;
    logic           last_wr;
    logic [KW-1:0]  step_k_site;
    logic [RAW-1:0] rd_addr;
    logic [RAW-1:0] wr_addr;
    logic [31:0]    wr_data;
    logic           wr_en;
    logic [31:0]    rd_data;

    logic signed [32:0] f_d;
    logic signed [65:0] f_prod;
    logic signed [34:0] nb_sum;
    logic signed [67:0] t1_prod;
    logic signed [67:0] t2_prod;
    logic signed [38:0] y_full;
    logic [31:0]        y_clamp;

    // ring size and saturated coefficients
    always_comb begin
        cnt_ext = CW'(r_site_count);
        if (cnt_ext < CW'(MIN_SITES)) begin
            ring_n = CW'(MIN_SITES);
        end else if (cnt_ext > CW'(MAX_SITES)) begin
            ring_n = CW'(MAX_SITES);
        end else begin
            ring_n = cnt_ext;
        end
        a_sat  = (r_gain_a > PARAM_SAT) ? PARAM_SAT : r_gain_a;
        e_sat  = (r_eps > PARAM_SAT) ? PARAM_SAT : r_eps;
        c_coef = ONE_Q32 - {e_sat, 1'b0};
    end

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;
    assign idx_ok   = CW'(i_in_data.site_index) < ring_n;
    assign issue    = (r_state == ST_STEP) && (r_k <= KW'(ring_n) + KW'(1));
    assign last_wr  = r_v5 && (r_wsite == ring_n - CW'(1));

    // site read order of a step: last, 0 .. n-1, first
    always_comb begin
        if (r_k == '0) begin
            step_k_site = KW'(ring_n) - KW'(1);
        end else if (r_k == KW'(ring_n) + KW'(1)) begin
            step_k_site = '0;
        end else begin
            step_k_site = r_k - KW'(1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_in_data.operation == OP_READ) begin
                    n_state = ST_READ;
                end else if (in_xfer && i_in_data.operation == OP_STEP) begin
                    n_state = ST_STEP;
                end
            end
            ST_READ: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            ST_STEP: begin
                if (last_wr) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs: stall, ram read address, result load
    always_comb begin
        o_in_stall = 1'b1;
        out_load   = 1'b0;
        rd_addr    = r_raddr;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                rd_addr    = {r_bank, AW'(i_in_data.site_index)};
            end
            ST_READ: begin
                out_load = !r_out_valid || !i_out_stall;
            end
            ST_STEP: begin
                rd_addr = {r_bank, step_k_site[AW-1:0]};
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    // write port: loads in idle, step results otherwise
    always_comb begin
        if (r_v5) begin
            wr_en   = 1'b1;
            wr_addr = {~r_bank, r_wsite[AW-1:0]};
            wr_data = y_clamp;
        end else begin
            wr_en   = in_xfer && (i_in_data.operation == OP_LOAD) && idx_ok;
            wr_addr = {r_bank, AW'(i_in_data.site_index)};
            wr_data = i_in_data.site_value;
        end
    end

    clml_ram #(
        .WIDTH (32),
        .DEPTH (2 * (2 ** AW))
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // site update arithmetic: f product, both coupling products, output clamp
    always_comb begin
        f_d     = $signed(ONE_Q31) - $signed({1'b0, rd_data});
        f_prod  = $signed({1'b0, rd_data}) * f_d;
        nb_sum  = r_fl + r_fr;
        t1_prod = $signed({1'b0, c_coef}) * r_fc;
        t2_prod = $signed({1'b0, e_sat}) * nb_sum;
        y_full  = r_p[67:29];
        if (y_full < 0) begin
            y_clamp = '0;
        end else if (y_full[38:32] != '0) begin
            y_clamp = '1;
        end else begin
            y_clamp = y_full[31:0];
        end
    end

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_a     <= GAIN_A_RESET;
            r_eps        <= EPS_RESET;
            r_site_count <= SITES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GAIN_A:       r_gain_a     <= i_cfg_data;
                CFG_COUPLING_EPS: r_eps        <= i_cfg_data;
                CFG_SITE_COUNT:   r_site_count <= i_cfg_data[8:0];
                default:          r_gain_a     <= r_gain_a;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_wsite     <= '0;
            r_fcnt      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            if (in_xfer && i_in_data.operation == OP_STEP) begin
                r_k     <= '0;
                r_wsite <= '0;
                r_fcnt  <= '0;
            end else begin
                if (issue) begin
                    r_k <= r_k + KW'(1);
                end
                if (r_v1 && r_fcnt != 2'd2) begin
                    r_fcnt <= r_fcnt + 2'd1;
                end
                if (r_v5) begin
                    r_wsite <= r_wsite + CW'(1);
                end
            end
            if (last_wr) begin
                r_bank <= ~r_bank;
            end
            r_v1 <= issue;
            r_v2 <= r_v1 && (r_fcnt == 2'd2);
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // read bookkeeping and result register
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_raddr  <= rd_addr;
            r_rd_idx <= i_in_data.site_index;
            r_rd_oor <= !idx_ok;
        end
        if (out_load) begin
            r_out_data.read_index <= r_rd_idx;
            r_out_data.read_value <= r_rd_oor ? 32'd0 : rd_data;
        end
    end

    // step pipeline: f window, coupling terms, sum, gain product
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_fl <= r_fc;
            r_fc <= r_fr;
            r_fr <= f_prod[64:31];
        end
        if (r_v2) begin
            r_t1 <= t1_prod[65:32];
            r_t2 <= t2_prod[65:32];
        end
        if (r_v3) begin
            r_s <= 35'(r_t1) + 35'(r_t2);
        end
        if (r_v4) begin
            r_p <= $signed({1'b0, a_sat}) * r_s;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
